@@ rtl/was_pkg.sv @@
// Package with the shared types and constants of the word array sorter.
package was_pkg;
    localparam int WORD_W = 16;
    typedef logic signed [WORD_W-1:0] t_word;
    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_RDA  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_OUTR = 3'd3;
    localparam logic [2:0] ST_OUTW = 3'd4;
    localparam logic [2:0] ST_OUTV = 3'd5;
endpackage

@@ rtl/word_array_sorter_top.sv @@
// Top level of the word array sorter.
// Words are taken one per cycle into a store until the beat marked last. The run
// is then sorted by insertion sort in the same memory: each word is held, and
// earlier words are read one per cycle and moved up while they must follow it,
// through the single read and write port of the store. The sorted run is then
// read back one word at a time through ST_OUTR, ST_OUTW and ST_OUTV, each word
// held in ST_OUTV until the output takes it. No input is taken while sorting or
// emitting.
module word_array_sorter_top
    import was_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // value
    input  logic        s_axis_tlast,  // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // sorted_value
    output logic        m_axis_tlast,  // last_out
    output logic        m_axis_tuser   // overflow
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt, r_i, r_j, r_k;
    logic          r_ovf, r_desc;
    t_word         r_key;
    t_word         r_odata;
    logic          r_olast;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_word         wdata, rdata;
    logic          key_first;

    was_store #(.DEPTH(MAX_ITEMS), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_FILL);
    assign m_axis_tvalid = (r_state == ST_OUTV);
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ovf;

    // The key goes before the stored word read at r_j - 1.
    assign key_first = r_desc ? (r_key > rdata) : (r_key < rdata);

    always_comb begin
        we    = 1'b0;
        waddr = r_cnt[AW-1:0];
        wdata = s_axis_tdata;
        raddr = r_i[AW-1:0];
        case (r_state)
            ST_FILL: begin
                we = s_axis_tvalid && (r_cnt != FULL);
            end
            ST_RDA: begin
                raddr = r_i[AW-1:0];
            end
            ST_CMP: begin
                waddr = r_j[AW-1:0];
                if (r_j != '0 && r_k == r_j && key_first) begin
                    we = 1'b1;
                    wdata = rdata;
                end else if (r_k == r_j) begin
                    we = 1'b1;
                    wdata = r_key;
                end
                if (r_k != r_j) begin
                    raddr = AW'(r_j - CW'(1));
                end else begin
                    raddr = AW'(r_j - CW'(2));
                end
            end
            ST_OUTR: begin
                raddr = r_i[AW-1:0];
            end
            default: begin
            end
        endcase
    end

    // In ST_CMP, r_k == r_j marks that rdata holds the word at r_j - 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_desc  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_desc <= i_cfg_data;
            end
            case (r_state)
                ST_FILL: begin
                    if (s_axis_tvalid) begin
                        if (r_cnt != FULL) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_i <= CW'(1);
                            r_state <= ST_RDA;
                        end
                    end
                end
                ST_RDA: begin
                    if (r_i >= r_cnt) begin
                        r_i <= '0;
                        r_state <= ST_OUTR;
                    end else begin
                        r_state <= ST_CMP;
                        r_j <= r_i;
                        r_k <= '0;
                    end
                end
                ST_CMP: begin
                    if (r_k != r_j) begin
                        // First cycle: rdata is the key at r_i.
                        r_key <= rdata;
                        if (r_j == '0) begin
                            r_k <= r_j;
                        end else begin
                            r_k <= r_j;
                        end
                    end else if (r_j != '0 && key_first) begin
                        r_j <= r_j - CW'(1);
                        r_k <= r_j - CW'(1);
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_state <= ST_RDA;
                    end
                end
                ST_OUTR: begin
                    r_state <= ST_OUTW;
                end
                ST_OUTW: begin
                    r_odata <= rdata;
                    r_olast <= (r_i + CW'(1) == r_cnt);
                    r_state <= ST_OUTV;
                end
                ST_OUTV: begin
                    if (m_axis_tready) begin
                        if (r_olast) begin
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                            r_state <= ST_FILL;
                        end else begin
                            r_i <= r_i + CW'(1);
                            r_state <= ST_OUTR;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end
endmodule

@@ rtl/was_store.sv @@
// Word store: one synchronous memory with one write port and one registered read port.
module was_store
    import was_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);
    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/was_checker.sv @@
// Port checker for the word array sorter, bound to the top level.
module was_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tlast,
    input logic m_axis_tuser
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("input taken while emitting");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_ovf_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        !m_axis_tvalid || m_axis_tuser == $past(m_axis_tuser))
        else $error("overflow flag changed within a run");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
        else $error("no return to filling after the last beat");
endmodule

bind word_array_sorter_top was_checker u_was_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
